>>> src/yrgb_pkg.sv
`default_nettype none

package yrgb_pkg;

  // Fraction bits of the 16.16 coefficients.
  localparam int unsigned FracBits = 16;

  // Product and sum widths. The largest product magnitude is below 2^25.
  // The largest sum magnitude is below 2^26.
  localparam int unsigned ProdW = 26;
  localparam int unsigned SumW  = 28;

  localparam int CoefLuma = 76309;
  localparam int CoefRv   = 104597;
  localparam int CoefGu   = 25675;
  localparam int CoefGv   = 53279;
  localparam int CoefBu   = 132201;

  localparam logic signed [8:0] LumaOfs   = 9'sd16;
  localparam logic signed [8:0] ChromaOfs = 9'sd128;

  typedef logic signed [8:0]       ofs_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } blk_t;

  typedef struct packed {
    logic [7:0] red_top_left;
    logic [7:0] green_top_left;
    logic [7:0] blue_top_left;
    logic [7:0] red_top_right;
    logic [7:0] green_top_right;
    logic [7:0] blue_top_right;
    logic [7:0] red_bottom_left;
    logic [7:0] green_bottom_left;
    logic [7:0] blue_bottom_left;
    logic [7:0] red_bottom_right;
    logic [7:0] green_bottom_right;
    logic [7:0] blue_bottom_right;
  } rgb_t;

  // One converted pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Chroma terms shared by all four pixels of a block.
  typedef struct packed {
    prod_t rc;
    prod_t gc;
    prod_t bc;
  } chroma_t;

  // Removes the offset from a byte.
  function automatic ofs_t remove_ofs(logic [7:0] val, ofs_t ofs);
    return $signed({1'b0, val}) - ofs;
  endfunction

endpackage

`default_nettype wire

>>> src/yrgb_blk_if.sv
`default_nettype none

interface yrgb_blk_if;
  import yrgb_pkg::*;

  logic valid;
  logic ready;
  blk_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/yrgb_rgb_if.sv
`default_nettype none

interface yrgb_rgb_if;
  import yrgb_pkg::*;

  logic valid;
  logic ready;
  rgb_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/yuv420_block_to_rgb.sv
`default_nettype none

// Converts one 2x2 block of a 4:2:0 image (four luma bytes and the shared u
// and v bytes) into four RGB pixels. It uses the BT.601 studio-range equations
// with 16.16 fixed-point coefficients. Each component is floored and saturated
// to 0..255. The block holds no state beyond its pipeline and has no
// configuration. It takes one block per clock cycle while the output is not
// stalled. The three register stages are the constant multiplies, the green
// chroma sum, and the per-pixel sums with saturation into the output register.
// Every stage holds its own valid bit. A stage advances whenever the stage after
// it is empty or is moving on, so a stall on the output side fills the bubbles
// first and then holds the data. No block is lost or repeated. Input ready
// depends combinationally on output ready through this chain.
module yuv420_block_to_rgb
  import yrgb_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  yrgb_blk_if.sink   blk_i,
  yrgb_rgb_if.source rgb_o
);

  localparam int unsigned NumPix = 4;

  // Stage ready chain: a stage can load when it is empty or draining.
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic blk_xfer;

  logic s1_valid_q;
  logic s2_valid_q;
  logic s3_valid_q;

  assign s3_ready    = !s3_valid_q || rgb_o.ready;
  assign s2_ready    = !s2_valid_q || s3_ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign blk_i.ready = s1_ready;
  assign blk_xfer    = blk_i.valid && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= blk_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // Stage 1: remove the offsets and multiply by the constant coefficients.
  // The luma term depends on the pixel, and the chroma terms are shared.
  logic [7:0] luma [NumPix];
  ofs_t       u_ofs;
  ofs_t       v_ofs;

  prod_t s1_luma_d [NumPix];
  prod_t s1_luma_q [NumPix];
  prod_t s1_rc_d, s1_gu_d, s1_gv_d, s1_bc_d;
  prod_t s1_rc_q, s1_gu_q, s1_gv_q, s1_bc_q;

  assign luma[0] = blk_i.data.luma_top_left;
  assign luma[1] = blk_i.data.luma_top_right;
  assign luma[2] = blk_i.data.luma_bottom_left;
  assign luma[3] = blk_i.data.luma_bottom_right;

  assign u_ofs = remove_ofs(blk_i.data.chroma_blue, ChromaOfs);
  assign v_ofs = remove_ofs(blk_i.data.chroma_red, ChromaOfs);

  always_comb begin
    for (int i = 0; i < NumPix; i++) begin
      s1_luma_d[i] = prod_t'(remove_ofs(luma[i], LumaOfs) * CoefLuma);
    end
    s1_rc_d = prod_t'(v_ofs * CoefRv);
    s1_gu_d = prod_t'(u_ofs * CoefGu);
    s1_gv_d = prod_t'(v_ofs * CoefGv);
    s1_bc_d = prod_t'(u_ofs * CoefBu);
  end

  always_ff @(posedge clk_i) begin
    if (blk_xfer) begin
      s1_luma_q <= s1_luma_d;
      s1_rc_q   <= s1_rc_d;
      s1_gu_q   <= s1_gu_d;
      s1_gv_q   <= s1_gv_d;
      s1_bc_q   <= s1_bc_d;
    end
  end

  // Stage 2: fold the two green chroma products into one term.
  prod_t   s2_luma_q [NumPix];
  chroma_t s2_chroma_d;
  chroma_t s2_chroma_q;

  assign s2_chroma_d.rc = s1_rc_q;
  assign s2_chroma_d.gc = s1_gu_q + s1_gv_q;
  assign s2_chroma_d.bc = s1_bc_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_luma_q   <= s1_luma_q;
      s2_chroma_q <= s2_chroma_d;
    end
  end

  // Stage 3: per-pixel sums and saturation, registered at the output.
  pix_t pix [NumPix];
  rgb_t rgb_d;
  rgb_t rgb_q;

  for (genvar p = 0; p < NumPix; p++) begin : g_pix
    yrgb_pixel u_pixel (
      .luma_term_i (s2_luma_q[p]),
      .chroma_i    (s2_chroma_q),
      .pix_o       (pix[p])
    );
  end

  always_comb begin
    rgb_d.red_top_left       = pix[0].red;
    rgb_d.green_top_left     = pix[0].green;
    rgb_d.blue_top_left      = pix[0].blue;
    rgb_d.red_top_right      = pix[1].red;
    rgb_d.green_top_right    = pix[1].green;
    rgb_d.blue_top_right     = pix[1].blue;
    rgb_d.red_bottom_left    = pix[2].red;
    rgb_d.green_bottom_left  = pix[2].green;
    rgb_d.blue_bottom_left   = pix[2].blue;
    rgb_d.red_bottom_right   = pix[3].red;
    rgb_d.green_bottom_right = pix[3].green;
    rgb_d.blue_bottom_right  = pix[3].blue;
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_ready) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o.valid = s3_valid_q;
  assign rgb_o.data  = rgb_q;

  // An accepted block always occupies the first stage on the next cycle.
  a_blk_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_xfer |=> s1_valid_q)
    else $error("accepted block did not reach stage 1");

  // A full middle stage that cannot move on keeps its valid bit and its data.
  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s3_ready) |=> (s2_valid_q && $stable(s2_chroma_q)))
    else $error("stalled stage 2 lost or changed its data");

  // A block that leaves stage 1 arrives in stage 2.
  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready) |=> s2_valid_q)
    else $error("stage 1 block dropped");

  // With the whole pipe full and the output stalled, the input is refused.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && s3_valid_q && !rgb_o.ready) |-> !blk_i.ready)
    else $error("input taken while pipeline full and stalled");

endmodule

`default_nettype wire

>>> src/yrgb_pixel.sv
`default_nettype none

module yrgb_pixel
  import yrgb_pkg::*;
(
  input  prod_t   luma_term_i,
  input  chroma_t chroma_i,
  output pix_t    pix_o
);

  sum_t red_sum;
  sum_t green_sum;
  sum_t blue_sum;

  // The floor of sum / 2^16 is the arithmetic shift. A negative sum gives 0,
  // and any quotient above 255 gives 255.
  function automatic logic [7:0] sat8(sum_t s);
    logic [7:0] res;
    if (s[SumW-1]) begin
      res = 8'd0;
    end else if (|s[SumW-2:FracBits+8]) begin
      res = 8'hff;
    end else begin
      res = s[FracBits+7:FracBits];
    end
    return res;
  endfunction

  assign red_sum   = sum_t'(luma_term_i) + sum_t'(chroma_i.rc);
  assign green_sum = sum_t'(luma_term_i) - sum_t'(chroma_i.gc);
  assign blue_sum  = sum_t'(luma_term_i) + sum_t'(chroma_i.bc);

  assign pix_o.red   = sat8(red_sum);
  assign pix_o.green = sat8(green_sum);
  assign pix_o.blue  = sat8(blue_sum);

endmodule

`default_nettype wire
